[hw/rtl/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Same-cycle implication, disabled during reset.
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

[hw/rtl/ipd_pkg.sv]
// Package: constants, types and command/status structs of the period detector.
`default_nettype none
package ipd_pkg;
    localparam int MAX_PERIOD = 256;
    localparam int CNT_W      = $clog2(MAX_PERIOD + 1);
    localparam int ADDR_W     = $clog2(MAX_PERIOD);
    localparam int SIG_W      = 16;
    localparam int FAC_W      = 12;
    localparam int SUM_W      = SIG_W + ADDR_W;
    localparam int THR_W      = FAC_W + SIG_W;
    localparam int DVD_W      = 2 * SIG_W;
    localparam int SQ_W       = 2 * SIG_W;
    localparam int RSS_W      = SQ_W + ADDR_W;
    localparam int ROOT_W     = RSS_W / 2;
    localparam int SQ_STEPS   = RSS_W / 2;
    localparam int SQ_CNT_W   = $clog2(SQ_STEPS);
    localparam int DIV_CNT_W  = $clog2(DVD_W);
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_W      = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_INTEG  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FACTOR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MINDEV = 2'd2;

    localparam logic             RST_INTEG  = 1'b1;
    localparam logic [FAC_W-1:0] RST_FACTOR = 12'd768;
    localparam logic [SIG_W-1:0] RST_MINDEV = 16'd256;
    localparam logic [SIG_W-1:0] SAT_MAX    = 16'hFFFF;

    typedef enum logic [3:0] {
        S_IDLE, S_EVAL, S_DECIDE, S_RDIV, S_BRANCH, S_APPEND, S_MDIV,
        S_SCAN, S_DRAIN, S_SQRT, S_SDIVS, S_SDIV, S_OUT
    } t_state;

    typedef struct packed {
        logic load;
        logic noint;
        logic eval;
        logic decide;
        logic ratio_take;
        logic branch;
        logic append;
        logic mean_take;
        logic scan;
        logic sqrt_init;
        logic sqrt_step;
        logic sdiv_start;
        logic spread_take;
    } t_cmd;

    typedef struct packed {
        logic integ;
        logic need_div;
        logic is_new;
        logic div_done;
        logic scan_last;
        logic pipe_empty;
        logic sqrt_last;
    } t_status;
endpackage
`default_nettype wire

[hw/rtl/ipd_ram.sv]
// Generic single-port RAM with registered read.
`default_nettype none
module ipd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule
`default_nettype wire

[hw/rtl/ipd_div.sv]
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module ipd_div (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_start,
    input  wire logic [ipd_pkg::DVD_W-1:0] i_dividend,
    input  wire logic [ipd_pkg::THR_W-1:0] i_divisor,
    output logic                           o_done,
    output logic      [ipd_pkg::DVD_W-1:0] o_quotient
);
    import ipd_pkg::*;

    logic [DVD_W-1:0]     r_dvd;
    logic [THR_W-1:0]     r_dvs;
    logic [THR_W-1:0]     r_rem;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_busy;
    logic                 r_done;
    logic [THR_W:0]       n_trial;
    logic                 n_fit;

    always_comb begin
        n_trial = {r_rem, r_dvd[DVD_W-1]};
        n_fit   = n_trial >= {1'b0, r_dvs};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= !i_start && r_busy && (r_cnt == DIV_CNT_W'(DVD_W - 1));
            if (i_start) begin
                r_dvd  <= i_dividend;
                r_dvs  <= i_divisor;
                r_rem  <= '0;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= n_fit ? THR_W'(n_trial - {1'b0, r_dvs}) : n_trial[THR_W-1:0];
                r_dvd <= {r_dvd[DVD_W-2:0], n_fit};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DVD_W - 1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_dvd;
endmodule
`default_nettype wire

[hw/rtl/ipd_dp.sv]
// Datapath: config registers, period statistics, scan pipeline, square root, divider.
`default_nettype none
module ipd_dp (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [ipd_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [ipd_pkg::CFG_W-1:0]     i_cfg_data,
    input  wire logic [ipd_pkg::SIG_W-1:0]     i_signature,
    input  wire ipd_pkg::t_cmd                 i_cmd,
    output ipd_pkg::t_status                   o_status,
    output logic                               o_new_period,
    output logic      [ipd_pkg::SIG_W-1:0]     o_current_ratio,
    output logic      [ipd_pkg::SIG_W-1:0]     o_cutoff_ratio,
    output logic      [ipd_pkg::CNT_W-1:0]     o_frames_in_period
);
    import ipd_pkg::*;

    logic                 r_integ;
    logic [FAC_W-1:0]     r_factor;
    logic [SIG_W-1:0]     r_mindev;
    logic [CNT_W-1:0]     r_count;
    logic [SUM_W-1:0]     r_sum;
    logic [SIG_W-1:0]     r_mean;
    logic [SIG_W-1:0]     r_spread;
    logic [SIG_W-1:0]     r_sig;
    logic [SIG_W-1:0]     r_dev;
    logic [THR_W-1:0]     r_thr;
    logic                 r_new;
    logic                 r_needcur;
    logic [SIG_W-1:0]     r_ratio;
    logic [SIG_W-1:0]     r_cur;
    logic [SIG_W-1:0]     r_cut;
    logic [CNT_W-1:0]     r_idx;
    logic                 r_v1;
    logic                 r_v2;
    logic [SQ_W-1:0]      r_sq;
    logic [RSS_W-1:0]     r_rss;
    logic [RSS_W-1:0]     r_sv;
    logic [RSS_W-1:0]     r_root;
    logic [RSS_W-1:0]     r_bit;
    logic [SQ_CNT_W-1:0]  r_scnt;

    logic                 n_is_new;
    logic                 n_need_cur;
    logic [SUM_W-1:0]     n_sum;
    logic [CNT_W-1:0]     n_count;
    logic [SIG_W-1:0]     n_res;
    logic [RSS_W:0]       n_rplus;
    logic                 n_sfit;
    logic                 n_div_start;
    logic [DVD_W-1:0]     n_dividend;
    logic [THR_W-1:0]     n_divisor;
    logic [DVD_W-1:0]     n_sat_src;
    logic [SIG_W-1:0]     n_sat;
    logic [SIG_W-1:0]     n_rdata;
    logic                 n_div_done;
    logic [DVD_W-1:0]     n_quo;

    always_comb begin
        n_is_new   = (r_count >= CNT_W'(MAX_PERIOD)) ||
                     (r_count > CNT_W'(1) && r_dev > r_mindev &&
                      THR_W'({r_dev, 8'b0}) > r_thr);
        n_need_cur = r_count > CNT_W'(1) && r_count < CNT_W'(MAX_PERIOD);
        n_sum      = r_sum + SUM_W'(r_sig);
        n_count    = r_count + 1'b1;
        n_res      = (r_mean > n_rdata) ? r_mean - n_rdata : n_rdata - r_mean;
        n_rplus    = {1'b0, r_root} + {1'b0, r_bit};
        n_sfit     = {1'b0, r_sv} >= n_rplus;
        n_div_start = (i_cmd.decide && o_status.need_div) || i_cmd.append || i_cmd.sdiv_start;
        n_dividend = {r_dev, {SIG_W{1'b0}}};
        n_divisor  = r_thr;
        if (i_cmd.append) begin
            n_dividend = DVD_W'(n_sum);
            n_divisor  = THR_W'(n_count);
        end else if (i_cmd.sdiv_start) begin
            n_dividend = DVD_W'(r_root[ROOT_W-1:0]);
            n_divisor  = THR_W'(r_count);
        end
        n_sat_src = n_quo;
        n_sat     = (n_sat_src > DVD_W'(SAT_MAX)) ? SAT_MAX : n_sat_src[SIG_W-1:0];
    end

    always_comb begin
        o_status.integ      = r_integ;
        o_status.need_div   = (n_is_new || n_need_cur) && (r_thr != '0);
        o_status.is_new     = r_new;
        o_status.div_done   = n_div_done;
        o_status.scan_last  = r_idx == r_count - 1'b1;
        o_status.pipe_empty = !r_v1 && !r_v2;
        o_status.sqrt_last  = r_scnt == SQ_CNT_W'(SQ_STEPS - 1);
    end

    ipd_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (n_div_start),
        .i_dividend (n_dividend),
        .i_divisor  (n_divisor),
        .o_done     (n_div_done),
        .o_quotient (n_quo)
    );

    ipd_ram #(.WIDTH(SIG_W), .DEPTH(MAX_PERIOD)) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.append),
        .i_addr  (i_cmd.append ? r_count[ADDR_W-1:0] : r_idx[ADDR_W-1:0]),
        .i_wdata (r_sig),
        .o_rdata (n_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integ  <= RST_INTEG;
            r_factor <= RST_FACTOR;
            r_mindev <= RST_MINDEV;
            r_count  <= '0;
            r_sum    <= '0;
            r_mean   <= '0;
            r_spread <= '0;
            r_v1     <= 1'b0;
            r_v2     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_INTEG:  r_integ  <= i_cfg_data[0];
                    CFG_FACTOR: r_factor <= i_cfg_data[FAC_W-1:0];
                    CFG_MINDEV: r_mindev <= i_cfg_data[SIG_W-1:0];
                    default:    ;
                endcase
            end
            if (i_cmd.load) begin
                r_sig <= i_signature;
            end
            if (i_cmd.noint) begin
                r_count  <= '0;
                r_sum    <= '0;
                r_mean   <= '0;
                r_spread <= '0;
                r_new    <= 1'b1;
                r_cur    <= '0;
                r_cut    <= '0;
            end
            if (i_cmd.eval) begin
                r_dev <= (r_mean > r_sig) ? r_mean - r_sig : r_sig - r_mean;
                r_thr <= r_factor * r_spread;
            end
            if (i_cmd.decide) begin
                r_new     <= n_is_new;
                r_needcur <= n_need_cur;
                r_ratio   <= SAT_MAX;
            end
            if (i_cmd.ratio_take) begin
                r_ratio <= n_sat;
            end
            if (i_cmd.branch) begin
                r_cur <= r_needcur ? r_ratio : '0;
                r_cut <= r_new ? r_ratio : '0;
                if (r_new) begin
                    r_count  <= '0;
                    r_sum    <= '0;
                    r_mean   <= '0;
                    r_spread <= '0;
                end
            end
            if (i_cmd.append) begin
                r_count <= n_count;
                r_sum   <= n_sum;
                r_idx   <= '0;
                r_rss   <= '0;
            end
            if (i_cmd.mean_take) begin
                r_mean <= n_quo[SIG_W-1:0];
            end
            r_v1 <= i_cmd.scan;
            if (i_cmd.scan) begin
                r_idx <= r_idx + 1'b1;
            end
            r_v2 <= r_v1;
            if (r_v1) begin
                r_sq <= n_res * n_res;
            end
            if (r_v2) begin
                r_rss <= r_rss + RSS_W'(r_sq);
            end
            if (i_cmd.sqrt_init) begin
                r_sv   <= r_rss;
                r_root <= '0;
                r_bit  <= RSS_W'(1) << (RSS_W - 2);
                r_scnt <= '0;
            end else if (i_cmd.sqrt_step) begin
                if (n_sfit) begin
                    r_sv   <= RSS_W'({1'b0, r_sv} - n_rplus);
                    r_root <= (r_root >> 1) + r_bit;
                end else begin
                    r_root <= r_root >> 1;
                end
                r_bit  <= r_bit >> 2;
                r_scnt <= r_scnt + 1'b1;
            end
            if (i_cmd.spread_take) begin
                r_spread <= n_sat;
            end
        end
    end

    assign o_new_period       = r_new;
    assign o_current_ratio    = r_cur;
    assign o_cutoff_ratio     = r_cut;
    assign o_frames_in_period = r_count;
endmodule
`default_nettype wire

[hw/rtl/ipd_ctrl.sv]
// Controller: sequences one signature through the datapath.
`default_nettype none
module ipd_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    input  wire ipd_pkg::t_status i_status,
    output ipd_pkg::t_cmd         o_cmd
);
    import ipd_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (i_in_valid) n_state = S_EVAL;
            S_EVAL:   n_state = i_status.integ ? S_DECIDE : S_OUT;
            S_DECIDE: n_state = i_status.need_div ? S_RDIV : S_BRANCH;
            S_RDIV:   if (i_status.div_done) n_state = S_BRANCH;
            S_BRANCH: n_state = i_status.is_new ? S_OUT : S_APPEND;
            S_APPEND: n_state = S_MDIV;
            S_MDIV:   if (i_status.div_done) n_state = S_SCAN;
            S_SCAN:   if (i_status.scan_last) n_state = S_DRAIN;
            S_DRAIN:  if (i_status.pipe_empty) n_state = S_SQRT;
            S_SQRT:   if (i_status.sqrt_last) n_state = S_SDIVS;
            S_SDIVS:  n_state = S_SDIV;
            S_SDIV:   if (i_status.div_done) n_state = S_OUT;
            S_OUT:    if (i_out_ready) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_EVAL: begin
                o_cmd.noint = !i_status.integ;
                o_cmd.eval  = i_status.integ;
            end
            S_DECIDE: o_cmd.decide      = 1'b1;
            S_RDIV:   o_cmd.ratio_take  = i_status.div_done;
            S_BRANCH: o_cmd.branch      = 1'b1;
            S_APPEND: o_cmd.append      = 1'b1;
            S_MDIV:   o_cmd.mean_take   = i_status.div_done;
            S_SCAN:   o_cmd.scan        = 1'b1;
            S_DRAIN:  o_cmd.sqrt_init   = i_status.pipe_empty;
            S_SQRT:   o_cmd.sqrt_step   = 1'b1;
            S_SDIVS:  o_cmd.sdiv_start  = 1'b1;
            S_SDIV:   o_cmd.spread_take = i_status.div_done;
            S_OUT:    o_out_valid       = 1'b1;
            default:  ;
        endcase
    end
endmodule
`default_nettype wire

[hw/rtl/integration_period_detector_unit.sv]
// Top level of the integration period detector.
// Usage:
//  - Input channel i_in_valid/o_in_ready moves one Q8.8 signature per transfer.
//  - Output channel o_out_valid/i_out_ready moves one result per input transfer:
//    new-period flag, current and cut-off ratios, frames held in the period.
//  - Config port i_cfg_we/i_cfg_idx/i_cfg_data writes a register;
//    write only while no item is in flight.
//  - One item at a time: o_in_ready is high only when idle.
//  - Sequence: when the camera is not integrating the item goes straight to
//    the output; a new period adds the ratio divide (32 steps). An appended
//    frame also runs the mean and spread divides on the shared bit-serial
//    divider (up to three divides) and the one-entry-per-cycle scan of the
//    signature RAM followed by the 20-step square root.
//  - Reset (i_rst_n low, synchronous) restores register defaults and clears
//    the statistics; the signature RAM needs no clearing.
//  - A stalled receiver holds the result on the output ports; no new input
//    is taken until the result transfer completes.
`default_nettype none
module integration_period_detector_unit (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [ipd_pkg::SIG_W-1:0]     i_signature,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic                               o_new_period,
    output logic      [ipd_pkg::SIG_W-1:0]     o_current_ratio,
    output logic      [ipd_pkg::SIG_W-1:0]     o_cutoff_ratio,
    output logic      [ipd_pkg::CNT_W-1:0]     o_frames_in_period,
    input  wire logic                          i_cfg_we,
    input  wire logic [ipd_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [ipd_pkg::CFG_W-1:0]     i_cfg_data
);
    import ipd_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    ipd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    ipd_dp u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_idx          (i_cfg_idx),
        .i_cfg_data         (i_cfg_data),
        .i_signature        (i_signature),
        .i_cmd              (w_cmd),
        .o_status           (w_status),
        .o_new_period       (o_new_period),
        .o_current_ratio    (o_current_ratio),
        .o_cutoff_ratio     (o_cutoff_ratio),
        .o_frames_in_period (o_frames_in_period)
    );
endmodule
`default_nettype wire

[hw/rtl/ipd_checker.sv]
// Port-level checker for the period detector, bound to the top level.
`default_nettype none
`include "assert_macros.svh"
module ipd_checker (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          i_in_valid,
    input wire logic                          o_in_ready,
    input wire logic                          o_out_valid,
    input wire logic                          i_out_ready,
    input wire logic                          o_new_period,
    input wire logic [ipd_pkg::SIG_W-1:0]     o_cutoff_ratio,
    input wire logic [ipd_pkg::CNT_W-1:0]     o_frames_in_period
);
    import ipd_pkg::*;

    `ASSERT_SAME(a_one_side, i_clk, i_rst_n, o_out_valid, !o_in_ready)
    `ASSERT_NEXT(a_no_instant_result, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_out_valid)
    `ASSERT_SAME(a_new_empty, i_clk, i_rst_n, o_out_valid && o_new_period, o_frames_in_period == '0)
    `ASSERT_SAME(a_cut_only_new, i_clk, i_rst_n, o_out_valid && !o_new_period, o_cutoff_ratio == '0)
    `ASSERT_SAME(a_count_range, i_clk, i_rst_n, o_out_valid, o_frames_in_period <= CNT_W'(MAX_PERIOD))
endmodule

bind integration_period_detector_unit ipd_checker u_ipd_checker (.*);
`default_nettype wire
